// ===== rtl/core/stable_priority_queue_macros.svh =====
// Assertion macros shared by the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("spq assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT_ALWAYS(lbl, cond)
`define SPQ_ASSERT_IMPLY(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
// Types, codes and defaults shared by the stable priority queue modules.
package spq_pkg;

    // Default number of queue slots.
    localparam int CAPACITY_DEF = 16;

    // Operation codes of an input item.
    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_TRAV = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Input item.
    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] value;
        logic        [7:0]  rank;
    } spq_in_t;

    // Result item.
    typedef struct packed {
        logic signed [31:0] out_value;
        logic        [1:0]  status;
        logic               last;
    } spq_out_t;

    // One stored queue entry.
    typedef struct packed {
        logic signed [31:0] value;
        logic        [7:0]  rank;
    } entry_t;

    // What every cell of the chain does in a cycle.
    typedef enum logic [3:0] {
        CELL_HOLD   = 4'b0001,
        CELL_INSERT = 4'b0010,
        CELL_POP    = 4'b0100,
        CELL_ROTATE = 4'b1000
    } cell_op_t;

    // Control broadcast from the top level to all cells.
    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted queue chain with its compare and shift logic.
module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]   count,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_shift,
    input  spq_pkg::entry_t    right_entry,
    input  spq_pkg::entry_t    head_entry,
    output spq_pkg::entry_t    entry,
    output logic               shift
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_C1 = CNT_W'(IDX + 1);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occupied;
    logic            is_tail;

    // Slot holds a live entry when its index is below the fill count.
    assign occupied = (count > IDX_C);
    assign is_tail  = (count == IDX_C1);

    // Entries with a strictly larger rank move back to make room.
    assign shift = occupied && (entry_reg.rank > ctl.item.rank);

    // Next slot contents.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            spq_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            spq_pkg::CELL_INSERT:
            begin
                if (left_shift)
                begin
                    entry_next = left_entry;
                end
                else if (shift || (count == IDX_C))
                begin
                    entry_next = ctl.item;
                end
            end
            spq_pkg::CELL_POP:
            begin
                entry_next = right_entry;
            end
            spq_pkg::CELL_ROTATE:
            begin
                entry_next = is_tail ? head_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Slot storage; contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// Stable priority queue: sorted chain of cells with a registered result port.
//
// Input channel cmd (cmd_valid/cmd_ready) carries an item with mode, value
// and rank. Result channel rsp (rsp_valid/rsp_ready) carries out_value,
// status and last. Lower rank leaves first; equal ranks leave in arrival order.
// Enqueue and dequeue each give one result, valid in the cycle after the item
// is accepted; with the receiver ready they sustain one item per cycle,
// since every cell compares and shifts in the same cycle.
// Traverse of N stored entries gives N results at one per cycle while the
// receiver is ready, the first after the traverse busy register and then the
// result register are set, by rotating the chain once around through its head
// cell; the input is held until the busy flag clears with the last result. An
// empty traverse gives one result, valid in the cycle after acceptance.
// Mode 3 is accepted and ignored.
// Reset empties the queue and clears the result valid flag; the result payload
// and slot contents are not cleared; slots are never read before being written.
// When the receiver stalls, the result register holds its item and cmd_ready
// drops until the register can take the next result.
`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  spq_pkg::spq_in_t  cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_out_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               trav_busy_reg;
    logic               trav_busy_next;
    logic [CNT_W-1:0]   trav_left_reg;
    logic [CNT_W-1:0]   trav_left_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    spq_pkg::spq_out_t  rsp_reg;
    spq_pkg::spq_out_t  rsp_next;

    logic               out_free;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    spq_pkg::cell_ctl_t ctl;

    spq_pkg::entry_t    cell_entry [CAPACITY];
    spq_pkg::entry_t    left_entry_w [CAPACITY];
    spq_pkg::entry_t    right_entry_w [CAPACITY];
    logic [CAPACITY-1:0] left_shift_w;
    logic [CAPACITY-1:0] cell_shift;

    // Handshake: the result register is free when empty or being drained.
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = !trav_busy_reg && out_free;
    assign accept    = cmd_valid && cmd_ready;
    assign is_full   = (count_reg == CAP_C);
    assign is_empty  = (count_reg == '0);

    // Chain control for this cycle.
    always_comb
    begin
        ctl.item.value = cmd.value;
        ctl.item.rank  = cmd.rank;
        ctl.op         = spq_pkg::CELL_HOLD;
        if (trav_busy_reg && out_free)
        begin
            ctl.op = spq_pkg::CELL_ROTATE;
        end
        else if (accept && (cmd.mode == spq_pkg::MODE_ENQ) && !is_full)
        begin
            ctl.op = spq_pkg::CELL_INSERT;
        end
        else if (accept && (cmd.mode == spq_pkg::MODE_DEQ) && !is_empty)
        begin
            ctl.op = spq_pkg::CELL_POP;
        end
    end

    // Neighbor wiring of the cell chain.
    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_entry_w[g] = ctl.item;
                assign left_shift_w[g] = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry_w[g] = cell_entry[g-1];
                assign left_shift_w[g] = cell_shift[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_entry_w[g] = cell_entry[g];
            end
            else
            begin : g_inner
                assign right_entry_w[g] = cell_entry[g+1];
            end

            spq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .count       (count_reg),
                .left_entry  (left_entry_w[g]),
                .left_shift  (left_shift_w[g]),
                .right_entry (right_entry_w[g]),
                .head_entry  (cell_entry[0]),
                .entry       (cell_entry[g]),
                .shift       (cell_shift[g])
            );
        end
    endgenerate

    // Fill count, traverse progress and result register.
    always_comb
    begin
        count_next     = count_reg;
        trav_busy_next = trav_busy_reg;
        trav_left_next = trav_left_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        if (trav_busy_reg && out_free)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.out_value = cell_entry[0].value;
            rsp_next.status    = spq_pkg::ST_OK;
            rsp_next.last      = (trav_left_reg == ONE_C);
            trav_left_next     = trav_left_reg - ONE_C;
            trav_busy_next     = (trav_left_reg != ONE_C);
        end
        else if (accept)
        begin
            rsp_next.out_value = '0;
            rsp_next.status    = spq_pkg::ST_OK;
            rsp_next.last      = 1'b1;
            if (cmd.mode == spq_pkg::MODE_ENQ)
            begin
                rsp_valid_next = 1'b1;
                if (is_full)
                begin
                    rsp_next.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + ONE_C;
                end
            end
            else if (cmd.mode == spq_pkg::MODE_DEQ)
            begin
                rsp_valid_next = 1'b1;
                if (is_empty)
                begin
                    rsp_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_next.out_value = cell_entry[0].value;
                    count_next         = count_reg - ONE_C;
                end
            end
            else if (cmd.mode == spq_pkg::MODE_TRAV)
            begin
                if (is_empty)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    trav_busy_next = 1'b1;
                    trav_left_next = count_reg;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            trav_busy_reg <= 1'b0;
            trav_left_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            trav_busy_reg <= trav_busy_next;
            trav_left_reg <= trav_left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on fill count and traverse bookkeeping.
    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CAP_C)
    `SPQ_ASSERT_IMPLY(a_trav_range, trav_busy_reg, (trav_left_reg != '0) && (trav_left_reg <= count_reg))
    `SPQ_ASSERT_NEXT(a_full_drop, accept && (cmd.mode == spq_pkg::MODE_ENQ) && is_full, $stable(count_reg))
    `SPQ_ASSERT_IMPLY(a_busy_block, trav_busy_reg, !cmd_ready)

endmodule
